// ----- hw/rtl/gmmd_pkg.sv -----
package gmmd_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 12;

	localparam logic [CfgIdxW-1:0] CfgWidth = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgGoals = 2'd2;

	typedef struct packed {
		logic store_row;
		logic clear_start;
		logic clear_step;
		logic seed;
		logic rd_top;
		logic try_step;
		logic rd_cell;
		logic eval;
		logic rd_out;
		logic emit;
	} gmmd_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic top_empty;
		logic tries_done;
		logic in_range;
		logic search_done;
		logic out_done;
	} gmmd_sts_t;

endpackage

// ----- hw/rtl/gmmd_row_if.sv -----
interface gmmd_row_if;
	logic valid;
	logic ready;
	logic [63:0] row_wall_mask;
	logic [63:0] row_goal_mask;
	logic row_is_last;
	modport source(output valid, row_wall_mask, row_goal_mask, row_is_last, input ready);
	modport sink(input valid, row_wall_mask, row_goal_mask, row_is_last, output ready);
endinterface

// ----- hw/rtl/gmmd_res_if.sv -----
interface gmmd_res_if;
	logic valid;
	logic ready;
	logic [5:0] out_row;
	logic [63:0] visited_mask;
	logic [63:0] goal_mask;
	logic search_success;
	logic [11:0] goals_found;
	logic out_last;
	modport source(output valid, out_row, visited_mask, goal_mask, search_success,
		goals_found, out_last, input ready);
	modport sink(input valid, out_row, visited_mask, goal_mask, search_success,
		goals_found, out_last, output ready);
endinterface

// ----- hw/rtl/gmmd_ctrl.sv -----
module gmmd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  gmmd_pkg::gmmd_sts_t sts,
	output gmmd_pkg::gmmd_cmd_t cmd
);
	typedef enum logic [3:0] {
		ST_LOAD, ST_CLEAR, ST_SEED, ST_TOP, ST_TOPW, ST_TRY, ST_CELL, ST_EVAL,
		ST_ORD, ST_ORDW, ST_OUT
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		in_ready = (state_q == ST_LOAD);
		out_valid = (state_q == ST_OUT);
		cmd.store_row = in_valid && in_ready;
		cmd.clear_start = cmd.store_row && in_last;
		cmd.clear_step = (state_q == ST_CLEAR);
		cmd.seed = (state_q == ST_SEED);
		cmd.rd_top = (state_q == ST_TOP);
		cmd.try_step = (state_q == ST_TRY);
		cmd.rd_cell = (state_q == ST_CELL);
		cmd.eval = (state_q == ST_EVAL);
		cmd.rd_out = (state_q == ST_ORD);
		cmd.emit = out_valid && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: if (cmd.clear_start) state_q <= ST_CLEAR;
				ST_CLEAR: if (sts.clear_done) state_q <= ST_SEED;
				ST_SEED: state_q <= ST_TOP;
				ST_TOP: begin
					if (sts.top_empty) state_q <= ST_ORD;
					else state_q <= ST_TOPW;
				end
				ST_TOPW: state_q <= ST_TRY;
				ST_TRY: begin
					if (sts.tries_done || !sts.in_range) state_q <= ST_TOP;
					else state_q <= ST_CELL;
				end
				ST_CELL: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (sts.search_done) state_q <= ST_ORD;
					else state_q <= ST_TOP;
				end
				ST_ORD: state_q <= ST_ORDW;
				ST_ORDW: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) begin
						if (sts.out_done) state_q <= ST_LOAD;
						else state_q <= ST_ORD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// ----- hw/rtl/gmmd_dp.sv -----
module gmmd_dp #(
	parameter int unsigned STACK_DEPTH = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [11:0]         cfg_data,
	input  logic [63:0]         in_wall,
	input  logic [63:0]         in_goal,
	input  gmmd_pkg::gmmd_cmd_t cmd,
	output gmmd_pkg::gmmd_sts_t sts,
	output logic [5:0]          o_row,
	output logic [63:0]         o_visited,
	output logic [63:0]         o_goal,
	output logic                o_success,
	output logic [11:0]         o_found,
	output logic                o_last
);
	localparam int unsigned SpW = $clog2(STACK_DEPTH);

	logic [63:0] wall_mem [64];
	logic [63:0] goal_mem [64];
	logic [63:0] vis_mem [64];
	logic [16:0] stack_mem [STACK_DEPTH];

	logic [6:0] width_q, height_q;
	logic [11:0] need_q;
	logic [5:0] load_row_q;
	logic [6:0] h_q, w_q;
	logic [SpW:0] top_q;
	logic [11:0] found_q;
	logic done_q;
	logic [6:0] clr_q;
	logic [16:0] ent_q;
	logic [5:0] nr_q, nc_q;
	logic [1:0] path_q;
	logic [63:0] wall_rd_q, goal_rd_q, vis_rd_q;
	logic [5:0] orow_q;

	logic [5:0] er, ec;
	logic [1:0] ed, pth;
	logic [2:0] et;
	logic [6:0] tr, tc;
	logic inr;
	logic [63:0] bit_m;
	logic hit_wall, hit_vis, hit_goal;
	logic [11:0] found_nx;
	logic [SpW-1:0] top_idx;

	assign er = ent_q[16:11];
	assign ec = ent_q[10:5];
	assign ed = ent_q[4:3];
	assign et = ent_q[2:0];
	assign pth = ed + et[1:0];
	assign top_idx = SpW'(top_q - 1'b1);

	always_comb begin
		tr = {1'b0, er};
		tc = {1'b0, ec};
		inr = 1'b1;
		unique case (pth)
			2'd0: begin tc = tc + 7'd1; inr = (tc < w_q); end
			2'd1: begin tr = tr + 7'd1; inr = (tr < h_q); end
			2'd2: begin inr = (ec != 6'd0); tc = tc - 7'd1; end
			default: begin inr = (er != 6'd0); tr = tr - 7'd1; end
		endcase
	end

	assign bit_m = 64'd1 << nc_q;
	assign hit_wall = |(wall_rd_q & bit_m);
	assign hit_vis = |(vis_rd_q & bit_m);
	assign hit_goal = |(goal_rd_q & bit_m);
	assign found_nx = found_q + {11'd0, hit_goal};

	assign sts.clear_done = (clr_q == 7'd63);
	assign sts.top_empty = (top_q == '0) || done_q;
	assign sts.tries_done = et[2];
	assign sts.in_range = inr;
	assign sts.search_done = !hit_wall && !hit_vis && (found_nx == need_q);
	assign sts.out_done = ({1'b0, orow_q} == h_q - 7'd1);

	assign o_row = orow_q;
	assign o_goal = goal_rd_q;
	assign o_visited = vis_rd_q & ~((vis_rd_q & goal_rd_q) & ~{63'd0, orow_q == 6'd0});
	assign o_success = done_q;
	assign o_found = found_q;
	assign o_last = sts.out_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 7'd64;
			height_q <= 7'd64;
			need_q <= 12'd1;
			load_row_q <= '0;
			top_q <= '0;
			found_q <= '0;
			done_q <= 1'b0;
			clr_q <= '0;
			orow_q <= '0;
			h_q <= 7'd1;
			w_q <= 7'd1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gmmd_pkg::CfgWidth: width_q <= cfg_data[6:0];
					gmmd_pkg::CfgHeight: height_q <= cfg_data[6:0];
					gmmd_pkg::CfgGoals: need_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear_start) load_row_q <= '0;
			else if (cmd.store_row) load_row_q <= load_row_q + 6'd1;
			if (cmd.clear_start) begin
				clr_q <= '0;
				h_q <= (height_q == 7'd0) ? 7'd1 : (height_q > 7'd64) ? 7'd64 : height_q;
				w_q <= (width_q == 7'd0) ? 7'd1 : (width_q > 7'd64) ? 7'd64 : width_q;
				found_q <= '0;
				done_q <= 1'b0;
			end
			if (cmd.clear_step) clr_q <= clr_q + 7'd1;
			if (cmd.seed) begin
				top_q <= (SpW+1)'(1);
				orow_q <= '0;
			end
			if (cmd.try_step && et[2]) top_q <= top_q - 1'b1;
			if (cmd.eval && !hit_wall && !hit_vis) begin
				found_q <= found_nx;
				if (found_nx == need_q) done_q <= 1'b1;
				else if (top_q < (SpW+1)'(STACK_DEPTH)) top_q <= top_q + 1'b1;
			end
			if (cmd.emit) orow_q <= orow_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_row) begin
			wall_mem[load_row_q] <= in_wall;
			goal_mem[load_row_q] <= in_goal;
		end
		if (cmd.clear_step) vis_mem[clr_q[5:0]] <= (clr_q == 7'd0) ? 64'd1 : 64'd0;
		if (cmd.seed) stack_mem[0] <= '0;
		if (cmd.rd_top) ent_q <= stack_mem[top_idx];
		if (cmd.try_step && !et[2]) begin
			stack_mem[top_idx] <= {ent_q[16:3], et + 3'd1};
			nr_q <= tr[5:0];
			nc_q <= tc[5:0];
			path_q <= pth;
		end
		if (cmd.rd_cell) begin
			wall_rd_q <= wall_mem[nr_q];
			goal_rd_q <= goal_mem[nr_q];
			vis_rd_q <= vis_mem[nr_q];
		end
		if (cmd.eval && !hit_wall && !hit_vis) begin
			vis_mem[nr_q] <= vis_rd_q | bit_m;
			if (found_nx != need_q && top_q < (SpW+1)'(STACK_DEPTH))
				stack_mem[top_q[SpW-1:0]] <= {nr_q, nc_q, path_q, 3'd0};
		end
		if (cmd.rd_out) begin
			wall_rd_q <= wall_mem[orow_q];
			goal_rd_q <= goal_mem[orow_q];
			vis_rd_q <= vis_mem[orow_q];
		end
	end
endmodule

// ----- hw/rtl/grid_maze_multi_goal_dfs_core.sv -----
// A row that is not last is stored and gives no result. The last row starts a
// visited-row clear and a seed of the start cell, then a walk in which a try that pops
// or leaves the grid reads the stack top only and a try that reads a row also reads
// and checks that cell (one stack memory read port, one row read per try), at most about
// 4096*4 tries; then one result per grid row, each read out and held until it is taken.
// Throughput: one grid at a time. Reset clears control and configuration only.
module grid_maze_multi_goal_dfs_core #(
	parameter int unsigned STACK_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	gmmd_row_if.sink    row_in,
	gmmd_res_if.source  res_out
);
	gmmd_pkg::gmmd_cmd_t cmd;
	gmmd_pkg::gmmd_sts_t sts;

	gmmd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(row_in.valid), .in_last(row_in.row_is_last), .in_ready(row_in.ready),
		.out_ready(res_out.ready), .out_valid(res_out.valid),
		.sts(sts), .cmd(cmd)
	);

	gmmd_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_wall(row_in.row_wall_mask), .in_goal(row_in.row_goal_mask),
		.cmd(cmd), .sts(sts),
		.o_row(res_out.out_row), .o_visited(res_out.visited_mask),
		.o_goal(res_out.goal_mask), .o_success(res_out.search_success),
		.o_found(res_out.goals_found), .o_last(res_out.out_last)
	);
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	typedef struct {
		logic [5:0]  row;
		logic [63:0] visited;
		logic [63:0] goals;
		logic        success;
		logic [11:0] found;
		logic        last;
	} row_result_t;

	class maze_scoreboard;
		logic [63:0] wall_mem[64];
		logic [63:0] goal_mem[64];
		logic [63:0] seen[64];
		logic [6:0]  width_reg = 7'd64;
		logic [6:0]  height_reg = 7'd64;
		logic [11:0] need_reg = 12'd1;
		int unsigned load_ptr = 0;
		int unsigned errors = 0;
		row_result_t pending[$];

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		function int unsigned clamp_side(logic [6:0] v);
			if (v == 0)
				return 1;
			if (v > 64)
				return 64;
			return 32'(v);
		endfunction

		function void set_reg(logic [1:0] idx, logic [11:0] val);
			unique case (idx)
				gmmd_pkg::CfgWidth:  width_reg = val[6:0];
				gmmd_pkg::CfgHeight: height_reg = val[6:0];
				gmmd_pkg::CfgGoals:  need_reg = val;
				default: ;
			endcase
		endfunction

		// walk the maze depth first and queue one result per grid row
		function void walk_maze();
			int unsigned h, w, top, r, c, d, t, p, nr, nc;
			int s_row[4096], s_col[4096], s_dir[4096], s_try[4096];
			logic [11:0] count;
			logic done;
			logic [63:0] hit;
			row_result_t res;
			h = clamp_side(height_reg);
			w = clamp_side(width_reg);
			foreach (seen[i])
				seen[i] = '0;
			count = 0;
			done = 0;
			seen[0][0] = 1'b1;
			s_row[0] = 0; s_col[0] = 0; s_dir[0] = 0; s_try[0] = 0;
			top = 1;
			while (top > 0 && !done) begin
				r = s_row[top-1]; c = s_col[top-1];
				d = s_dir[top-1]; t = s_try[top-1];
				if (t >= 4) begin
					top--;
					continue;
				end
				s_try[top-1] = t + 1;
				p = (d + t) & 3;
				nr = r; nc = c;
				case (p)
					0: nc = c + 1;
					1: nr = r + 1;
					2: if (c == 0) continue; else nc = c - 1;
					default: if (r == 0) continue; else nr = r - 1;
				endcase
				if (nr >= h || nc >= w)
					continue;
				if (wall_mem[nr][nc] || seen[nr][nc])
					continue;
				if (goal_mem[nr][nc])
					count = count + 1;
				seen[nr][nc] = 1'b1;
				if (count == need_reg) begin
					done = 1;
					break;
				end
				if (top < 4096) begin
					s_row[top] = nr; s_col[top] = nc; s_dir[top] = p; s_try[top] = 0;
					top++;
				end
			end
			for (int unsigned i = 0; i < h; i++) begin
				hit = seen[i] & goal_mem[i];
				if (i == 0)
					hit[0] = 1'b0;
				res.row = 6'(i);
				res.visited = seen[i] & ~hit;
				res.goals = goal_mem[i];
				res.success = done;
				res.found = count;
				res.last = (i == h - 1);
				pending.insert(pending.size(), res);
			end
		endfunction

		function void note_row(logic [63:0] wall, logic [63:0] goal, logic last);
			wall_mem[load_ptr] = wall;
			goal_mem[load_ptr] = goal;
			if (!last) begin
				load_ptr = (load_ptr + 1) % 64;
			end else begin
				load_ptr = 0;
				walk_maze();
			end
		endfunction

		task check_result(row_result_t got);
			row_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result for row %0d", got.row));
				return;
			end
			want = pending.pop_front();
			if (got.row !== want.row)
				report($sformatf("out_row %0d, want %0d", got.row, want.row));
			if (got.visited !== want.visited)
				report($sformatf("row %0d visited_mask %h, want %h", want.row,
					got.visited, want.visited));
			if (got.goals !== want.goals)
				report($sformatf("row %0d goal_mask %h, want %h", want.row,
					got.goals, want.goals));
			if (got.success !== want.success)
				report($sformatf("row %0d search_success %b, want %b", want.row,
					got.success, want.success));
			if (got.found !== want.found)
				report($sformatf("row %0d goals_found %0d, want %0d", want.row,
					got.found, want.found));
			if (got.last !== want.last)
				report($sformatf("row %0d out_last %b, want %b", want.row,
					got.last, want.last));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [11:0] cfg_data = '0;
	logic calm = 0;
	int unsigned rows_sent = 0;

	gmmd_row_if row_bus();
	gmmd_res_if res_bus();

	maze_scoreboard sb = new();

	grid_maze_multi_goal_dfs_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.row_in(row_bus),
		.res_out(res_bus)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	function int unsigned gap_len();
		int unsigned k;
		if (calm)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 60)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	initial begin
		row_bus.valid = 0;
		row_bus.row_wall_mask = '0;
		row_bus.row_goal_mask = '0;
		row_bus.row_is_last = 0;
		res_bus.ready = 0;
	end

	// receiver side stalls
	initial begin
		int unsigned g;
		@(posedge arst_n);
		forever begin
			res_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			g = gap_len();
			if (g > 0) begin
				res_bus.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		row_result_t got;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got.row = res_bus.out_row;
			got.visited = res_bus.visited_mask;
			got.goals = res_bus.goal_mask;
			got.success = res_bus.search_success;
			got.found = res_bus.goals_found;
			got.last = res_bus.out_last;
			sb.check_result(got);
		end
	end

	task write_regs(logic [11:0] w, logic [11:0] h, logic [11:0] g);
		logic [11:0] vals[3];
		vals[0] = w; vals[1] = h; vals[2] = g;
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[1:0];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(i[1:0], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task send_row(logic [63:0] wall, logic [63:0] goal, logic last);
		int unsigned g;
		g = gap_len();
		if (g > 0) begin
			row_bus.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		row_bus.valid <= 1'b1;
		row_bus.row_wall_mask <= wall;
		row_bus.row_goal_mask <= goal;
		row_bus.row_is_last <= last;
		do @(posedge clk); while (!row_bus.ready);
		sb.note_row(wall, goal, last);
		rows_sent++;
	endtask

	// drain results, then let the block settle before touching registers
	task wait_idle();
		row_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// send n rows; mode picks the wall density
	task send_grid(int unsigned n, int unsigned mode);
		logic [63:0] wall, goal;
		for (int unsigned i = 0; i < n; i++) begin
			case (mode)
				0: wall = '0;
				1: wall = rand_word() & rand_word() & rand_word();
				2: wall = rand_word() & rand_word();
				default: wall = rand_word();
			endcase
			goal = ($urandom_range(0, 3) == 0) ? rand_word() : rand_word() & rand_word();
			send_row(wall, goal, i == n - 1);
		end
		wait_idle();
	endtask

	initial begin
		int unsigned h, w, n, g;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero sizes act as one cell; start cell both wall and goal
		write_regs(12'd0, 12'd0, 12'd0);
		send_row('1, '1, 1'b1);
		wait_idle();
		// wall over goal, goal beside the start
		write_regs(12'd3, 12'd2, 12'd1);
		send_row(64'h2, 64'h2, 1'b0);
		send_row(64'h0, 64'h4, 1'b1);
		wait_idle();
		// oversized width register, bits beyond width, unreachable goal count
		write_regs(12'd200, 12'd2, 12'd4095);
		send_row(64'h8000_0000_0000_0000, '1, 1'b0);
		send_row('0, 64'h5555_0000_0000_00F0, 1'b1);
		wait_idle();
		write_regs(12'd127, 12'd3, 12'd2);
		send_row('0, '1, 1'b0);
		send_row(rand_word() & rand_word(), '1, 1'b0);
		send_row('0, '0, 1'b1);
		wait_idle();
		// zero needed: success on first entered cell
		write_regs(12'd64, 12'd1, 12'd0);
		send_row('0, '0, 1'b1);
		wait_idle();
		// start boxed in
		write_regs(12'd4, 12'd4, 12'd3);
		send_row(64'h2, 64'hF, 1'b0);
		send_row(64'h1, 64'hF, 1'b0);
		send_row(64'h0, 64'hF, 1'b0);
		send_row(64'h0, 64'hF, 1'b1);
		wait_idle();

		// full-size grid, sparse walls, extra rows wrap the load pointer
		write_regs(12'd64, 12'd64, 12'd4095);
		calm = 1;
		send_grid(66, 1);
		calm = 0;

		while (rows_sent < 100) begin
			calm = ($urandom_range(0, 3) == 0);
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 10);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 8);
			g = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 5);
			write_regs(12'(w), 12'(h), 12'(g));
			n = sb.clamp_side(h[6:0]);
			if ($urandom_range(0, 4) == 0)
				n += $urandom_range(1, 3);
			send_grid(n, $urandom_range(0, 3));
		end

		calm = 0;
		wait_idle();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
